// File: rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared sizes, action and status codes, and the structs that pass between
// the allocator core and the top level.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int SLOTS    = 256;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int ELEM_W   = 32;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int IN_SLOT_W = 8;
  localparam int DATA_W   = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // One result beat.
  typedef struct packed {
    status_t              status;
    logic [IN_SLOT_W-1:0] granted_slot;
    logic [DATA_W-1:0]    read_data;
  } res_t;

  // Memory writes issued when the item in the execute stage commits.
  typedef struct packed {
    logic              stk_we;
    logic [SLOT_W-1:0] stk_waddr;
    logic [SLOT_W-1:0] stk_wdata;
    logic              sto_we;
    logic [SLOT_W-1:0] sto_waddr;
    logic [ELEM_W-1:0] sto_wdata;
  } wr_t;

  // Read setup for the next item; the stack address comes from the state after this commit.
  typedef struct packed {
    logic [SLOT_W-1:0] stk_raddr;
    logic              stk_init;
    logic              sto_vld;
  } rd_t;

endpackage

// File: rtl/slot_allocator_with_store_unit.sv
// Path: an accepted beat waits in the s1 registers, then its result is registered in out_r.
// Throughput: one beat per cycle unless out_stall holds a valid output; the free stack
// and store each take one read and one write per cycle, forwarding back-to-back writes.
// Reset: synchronous, active low; the pool is usable directly after reset,
// as the stack reset order comes from a low-water mark and the store from valid bits.
// ----------------------------------------------------------------------------
// Slot allocator with store
// Fixed pool of slots handed out from a LIFO free stack, with a data store
// that allocated slots can write and read.
// ----------------------------------------------------------------------------
module slot_allocator_with_store_unit
  import sas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [IN_SLOT_W-1:0] in_slot,
  input  logic [DATA_W-1:0]    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [IN_SLOT_W-1:0] out_granted_slot,
  output logic [DATA_W-1:0]    out_read_data
);

  logic                 out_ready;
  logic                 accept;
  logic                 s1_go;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [ACT_W-1:0]     s1_action_r;
  logic [IN_SLOT_W-1:0] s1_slot_r;
  logic [DATA_W-1:0]    s1_data_r;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_r;
  res_t                 res;
  wr_t                  wr;
  rd_t                  rd;
  logic [SLOT_W-1:0]    stk_q;
  logic [ELEM_W-1:0]    sto_q;
  logic                 stk_byp_r;
  logic [SLOT_W-1:0]    stk_bdata_r;
  logic                 stk_init_r;
  logic [SLOT_W-1:0]    stk_addr_r;
  logic                 sto_byp_r;
  logic [ELEM_W-1:0]    sto_bdata_r;
  logic                 sto_vld_r;
  logic [SLOT_W-1:0]    stk_top;
  logic [ELEM_W-1:0]    sto_rdata;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_go     = s1_vld_r && out_ready;
  assign in_stall  = s1_vld_r && !out_ready;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The memories are read at the accept edge, so forward any write that
  // lands on the same address at that same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_slot_r   <= in_slot;
      s1_data_r   <= in_data;
      stk_byp_r   <= wr.stk_we && (wr.stk_waddr == rd.stk_raddr);
      stk_bdata_r <= wr.stk_wdata;
      stk_init_r  <= rd.stk_init;
      stk_addr_r  <= rd.stk_raddr;
      sto_byp_r   <= wr.sto_we && (wr.sto_waddr == SLOT_W'(in_slot));
      sto_bdata_r <= wr.sto_wdata;
      sto_vld_r   <= rd.sto_vld;
    end
    if (s1_go) begin
      out_r <= res;
    end
  end

  always_comb begin
    if (stk_byp_r) begin
      stk_top = stk_bdata_r;
    end else if (stk_init_r) begin
      stk_top = SLOT_W'(SLOTS - 1) - stk_addr_r;
    end else begin
      stk_top = stk_q;
    end
    if (sto_byp_r) begin
      sto_rdata = sto_bdata_r;
    end else if (sto_vld_r) begin
      sto_rdata = sto_q;
    end else begin
      sto_rdata = '0;
    end
  end

  sas_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (wr.stk_we),
    .waddr (wr.stk_waddr),
    .wdata (wr.stk_wdata),
    .re    (accept),
    .raddr (rd.stk_raddr),
    .rdata (stk_q)
  );

  sas_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (SLOTS)
  ) u_store_ram (
    .clk   (clk),
    .we    (wr.sto_we),
    .waddr (wr.sto_waddr),
    .wdata (wr.sto_wdata),
    .re    (accept),
    .raddr (SLOT_W'(in_slot)),
    .rdata (sto_q)
  );

  sas_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .action    (s1_action_r),
    .slot      (s1_slot_r),
    .data      (s1_data_r),
    .stk_top   (stk_top),
    .sto_rdata (sto_rdata),
    .next_slot (in_slot),
    .res       (res),
    .wr        (wr),
    .rd        (rd)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_granted_slot = out_r.granted_slot;
  assign out_read_data    = out_r.read_data;

endmodule

// File: rtl/sas_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sas_core.sv
// ----------------------------------------------------------------------------
// Slot allocator core
// Holds the free count, the stack low-water mark, the in-use map and the
// store valid bits, decides each operation and issues the memory writes.
// ----------------------------------------------------------------------------
module sas_core
  import sas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [ACT_W-1:0]     action,
  input  logic [IN_SLOT_W-1:0] slot,
  input  logic [DATA_W-1:0]    data,
  input  logic [SLOT_W-1:0]    stk_top,
  input  logic [ELEM_W-1:0]    sto_rdata,
  input  logic [IN_SLOT_W-1:0] next_slot,
  output res_t                 res,
  output wr_t                  wr,
  output rd_t                  rd
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  lw_r, lw_nxt;
  logic [SLOTS-1:0]  in_use_r, in_use_nxt;
  logic [SLOTS-1:0]  sto_vld_r, sto_vld_nxt;
  logic [SLOT_W-1:0] sidx;
  logic              in_range;
  logic              pop;
  logic              push;
  logic              clr;
  logic              sto_we;

  assign sidx     = SLOT_W'(slot);
  assign in_range = 32'(slot) < SLOTS;

  always_comb begin
    res.status       = ST_OK;
    res.granted_slot = '0;
    res.read_data    = '0;
    pop              = 1'b0;
    push             = 1'b0;
    clr              = 1'b0;
    sto_we           = 1'b0;
    case (action_t'(action))
      ACT_ALLOC: begin
        if (cnt_r == '0) begin
          res.status = ST_FULL;
        end else begin
          pop              = 1'b1;
          res.granted_slot = IN_SLOT_W'(stk_top);
        end
      end
      default: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (!in_use_r[sidx]) begin
          res.status = ST_NOT_IN_USE;
        end else begin
          case (action_t'(action))
            ACT_FREE: begin
              clr  = 1'b1;
              push = cnt_r < CNT_W'(SLOTS);
            end
            ACT_WRITE: begin
              sto_we = 1'b1;
            end
            ACT_READ: begin
              res.read_data = DATA_W'(sto_rdata);
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    in_use_nxt  = in_use_r;
    sto_vld_nxt = sto_vld_r;
    if (fire && pop) begin
      cnt_nxt = cnt_r - 1'b1;
      in_use_nxt[stk_top] = 1'b1;
    end
    if (fire && push) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (fire && clr) begin
      in_use_nxt[sidx] = 1'b0;
    end
    if (fire && sto_we) begin
      sto_vld_nxt[sidx] = 1'b1;
    end
    // Stack entries below the low-water mark were never written since reset.
    lw_nxt = (cnt_nxt < lw_r) ? cnt_nxt : lw_r;
  end

  assign wr.stk_we    = fire && push;
  assign wr.stk_waddr = SLOT_W'(cnt_r);
  assign wr.stk_wdata = sidx;
  assign wr.sto_we    = fire && sto_we;
  assign wr.sto_waddr = sidx;
  assign wr.sto_wdata = ELEM_W'(data);

  assign rd.stk_raddr = SLOT_W'(cnt_nxt - 1'b1);
  assign rd.stk_init  = {1'b0, rd.stk_raddr} < lw_nxt;
  assign rd.sto_vld   = sto_vld_r[SLOT_W'(next_slot)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= CNT_W'(SLOTS);
      lw_r      <= CNT_W'(SLOTS);
      in_use_r  <= '0;
      sto_vld_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      lw_r      <= lw_nxt;
      in_use_r  <= in_use_nxt;
      sto_vld_r <= sto_vld_nxt;
    end
  end

endmodule
